// ===== rtl/swlm_pkg.sv =====
package swlm_pkg;

	// Register and field widths of the block's ports
	localparam int THR_W        = 15;
	localparam int SQ_W         = 2;
	localparam int FRAME_W      = 11;
	localparam int CFG_DATA_W   = 15;
	localparam int CFG_IDX_W    = 2;
	localparam int COORD_W      = 10;
	localparam int VALUE_W      = 15;
	localparam int OUT_FIELDS_W = 2 * COORD_W + VALUE_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Smallest frame extent the geometry clamps to
	localparam int MIN_FRAME_DIM = 8;

	// Register reset values
	localparam logic [THR_W-1:0]   THR_RESET   = 15'd0;
	localparam logic [SQ_W-1:0]    SQ_RESET    = 2'd1;
	localparam logic [FRAME_W-1:0] FRAME_RESET = 11'd1024;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD     = 2'd0,
		CFG_SQUARE_SIZE   = 2'd1,
		CFG_FRAME_COLUMNS = 2'd2,
		CFG_FRAME_ROWS    = 2'd3
	} cfg_reg_t;

	// Control that travels with a pixel into the window stage
	typedef struct packed {
		logic               valid;
		logic               elig;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} win_ctl_t;

	// One found peak, column in the lowest bits
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} peak_t;

endpackage

// ===== rtl/square_window_local_maximum_finder.sv =====
// Local maximum finder over a square window of a raster-scanned frame.
// Slave stream: one pixel per request, tdata carries the signed sample and
// tuser marks the first pixel of a frame (it restarts the position at column
// 0, row 0). Master stream: one request per peak found, carrying column, row
// and value of the centre pixel. A peak is reported when the pixel that
// completes its window (square_size rows below, square_size columns right)
// is accepted; its request passes the stage 1, window and output registers.
// Throughput is one pixel per clock unless stalled: every row memory of the
// line buffer takes one write and one read per cycle, and the window compare
// sits in a single stage. Configuration must be written through the plain
// write port while the stream is idle; the block does not enforce it. Reset
// clears the position counters, the pipeline valid bits and the registers to
// threshold 0, half width 1, 1024 x 1024 frame; the line memories are not
// cleared. When the receiver stalls, one peak waits in the output register
// and one more in a skid register; tready on the slave side falls only once
// the skid register is occupied, and the whole pipeline then holds.
module square_window_local_maximum_finder #(
	parameter int MAX_COLUMNS    = 1024,
	parameter int MAX_ROWS       = 1024,
	parameter int MAX_HALF_WIDTH = 3,
	parameter int PIXEL_BITS     = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [swlm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swlm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]      s_axis_tdata,  // pixel_value
	input  logic                                 s_axis_tuser,  // start_of_frame
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [swlm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // peak_column, peak_row, peak_value
);

	import swlm_pkg::*;

	localparam int LINES = 2 * MAX_HALF_WIDTH + 1;
	localparam int LW    = $clog2(LINES);
	localparam int CW    = $clog2(MAX_COLUMNS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CPW   = CW + 1;
	localparam int RPW   = RW + 1;
	localparam int HW_W  = $clog2(MAX_HALF_WIDTH + 1);
	localparam int CFW   = (CPW > FRAME_W) ? CPW : FRAME_W;
	localparam int RFW   = (RPW > FRAME_W) ? RPW : FRAME_W;
	localparam int SQX_W = HW_W + SQ_W;
	localparam int CXW   = CW + HW_W + 1;
	localparam int RXW   = RW + HW_W + 1;

	logic [THR_W-1:0]   thr_q;
	logic [SQ_W-1:0]    sq_q;
	logic [FRAME_W-1:0] fcols_q;
	logic [FRAME_W-1:0] frows_q;

	logic [CFW-1:0]     fcols_x;
	logic [RFW-1:0]     frows_x;
	logic [SQX_W-1:0]   sq_x;
	logic [CPW-1:0]     cols_eff;
	logic [RPW-1:0]     rows_eff;
	logic [HW_W-1:0]    s_eff;
	logic [HW_W:0]      two_s;

	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [LW-1:0]      line_q;
	logic [CW-1:0]      c_in;
	logic [RW-1:0]      r_in;
	logic [LW-1:0]      line_in;
	logic [CPW-1:0]     col_inc;
	logic [RPW-1:0]     row_inc;
	logic [CXW-1:0]     cx;
	logic [RXW-1:0]     cy;
	logic               elig;

	logic                          accept;
	logic                          en;
	logic [PIXEL_BITS-1:0]         pix_in;
	logic [PIXEL_BITS-1:0]         pix_s1;
	logic [LW-1:0]                 line_s1;
	win_ctl_t                      ctl_s1;
	logic [LINES-1:0][PIXEL_BITS-1:0] rd_line;
	logic                          hit;
	peak_t                         peak;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			sq_q    <= SQ_RESET;
			fcols_q <= FRAME_RESET;
			frows_q <= FRAME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD:     thr_q   <= cfg_data[THR_W-1:0];
				CFG_SQUARE_SIZE:   sq_q    <= cfg_data[SQ_W-1:0];
				CFG_FRAME_COLUMNS: fcols_q <= cfg_data[FRAME_W-1:0];
				CFG_FRAME_ROWS:    frows_q <= cfg_data[FRAME_W-1:0];
			endcase
		end
	end

	// Clamp geometry and half width into their supported ranges
	always_comb begin
		fcols_x = CFW'(fcols_q);
		frows_x = RFW'(frows_q);
		sq_x    = SQX_W'(sq_q);
		if (fcols_x < CFW'(MIN_FRAME_DIM)) begin
			cols_eff = CPW'(MIN_FRAME_DIM);
		end else if (fcols_x > CFW'(MAX_COLUMNS)) begin
			cols_eff = CPW'(MAX_COLUMNS);
		end else begin
			cols_eff = CPW'(fcols_x);
		end
		if (frows_x < RFW'(MIN_FRAME_DIM)) begin
			rows_eff = RPW'(MIN_FRAME_DIM);
		end else if (frows_x > RFW'(MAX_ROWS)) begin
			rows_eff = RPW'(MAX_ROWS);
		end else begin
			rows_eff = RPW'(frows_x);
		end
		if (sq_x == '0) begin
			s_eff = HW_W'(1);
		end else if (sq_x > SQX_W'(MAX_HALF_WIDTH)) begin
			s_eff = HW_W'(MAX_HALF_WIDTH);
		end else begin
			s_eff = HW_W'(sq_x);
		end
		two_s = {s_eff, 1'b0};
	end

	assign accept = s_axis_tvalid && s_axis_tready;
	assign pix_in = s_axis_tdata[PIXEL_BITS-1:0];

	// Position of the incoming pixel; a frame start forces the origin
	assign c_in    = s_axis_tuser ? '0 : col_q;
	assign r_in    = s_axis_tuser ? '0 : row_q;
	assign line_in = s_axis_tuser ? '0 : line_q;
	assign col_inc = CPW'(c_in) + CPW'(1);
	assign row_inc = RPW'(r_in) + RPW'(1);

	// Window complete and centre clear of every edge
	assign elig = (CXW'(c_in) >= CXW'(two_s)) && (CPW'(c_in) < cols_eff) &&
	              (RXW'(r_in) >= RXW'(two_s)) && (RPW'(r_in) < rows_eff);
	assign cx   = CXW'(c_in) - CXW'(s_eff);
	assign cy   = RXW'(r_in) - RXW'(s_eff);

	// Advance the raster position, wrapping at row and frame ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			line_q <= '0;
		end else if (accept) begin
			if (col_inc >= cols_eff) begin
				col_q <= '0;
				if (row_inc >= rows_eff) begin
					row_q  <= '0;
					line_q <= '0;
				end else begin
					row_q  <= row_inc[RW-1:0];
					line_q <= (line_in == LW'(LINES - 1)) ? '0 : line_in + LW'(1);
				end
			end else begin
				col_q  <= col_inc[CW-1:0];
				row_q  <= r_in;
				line_q <= line_in;
			end
		end
	end

	assign s_axis_tready = en;

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= accept;
			ctl_s1.elig  <= elig;
			ctl_s1.col   <= COORD_W'(cx);
			ctl_s1.row   <= COORD_W'(cy);
		end
	end

	// Stage 1 payload, taken with the line reads
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix_in;
			line_s1 <= line_in;
		end
	end

	swlm_line_buf #(
		.LINES      (LINES),
		.DEPTH      (MAX_COLUMNS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (accept),
		.wr_line (line_in),
		.addr    (c_in),
		.wr_data (pix_in),
		.rd_data (rd_line)
	);

	swlm_window #(
		.LINES      (LINES),
		.PIXEL_BITS (PIXEL_BITS),
		.HW_W       (HW_W)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_s1     (ctl_s1),
		.pix_s1     (pix_s1),
		.line_s1    (line_s1),
		.rd_line    (rd_line),
		.half_width (s_eff),
		.threshold  (thr_q),
		.hit        (hit),
		.peak       (peak)
	);

	swlm_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hit),
		.in_data   (peak),
		.space_ok  (en),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// The slave side only stalls while results are backed up on the master side
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

	// The line pointer always names the row modulo the line count
	a_line_tracks_row: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(row_q) % LINES) == int'(line_q))
		else $error("line pointer out of step with row");

	// A frame start places the next pixel at column 1 of row 0
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tuser |=> (col_q == CW'(1)) && (row_q == '0))
		else $error("frame start did not restart the position");

endmodule

// ===== rtl/swlm_line_buf.sv =====
module swlm_line_buf #(
	parameter int LINES      = 7,
	parameter int DEPTH      = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [$clog2(LINES)-1:0]            wr_line,
	input  logic [$clog2(DEPTH)-1:0]            addr,
	input  logic [PIXEL_BITS-1:0]               wr_data,
	output logic [LINES-1:0][PIXEL_BITS-1:0]    rd_data
);

	localparam int LW = $clog2(LINES);

	// One row memory per line: write the owning line, read every line at the same column
	for (genvar g = 0; g < LINES; g++) begin : g_line
		logic [PIXEL_BITS-1:0] mem [DEPTH];
		logic [PIXEL_BITS-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (wr_en) begin
				if (wr_line == LW'(g)) begin
					mem[addr] <= wr_data;
				end
				rd_q <= mem[addr];
			end
		end

		assign rd_data[g] = rd_q;
	end

endmodule

// ===== rtl/swlm_window.sv =====
module swlm_window #(
	parameter int LINES      = 7,
	parameter int PIXEL_BITS = 16,
	parameter int HW_W       = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  swlm_pkg::win_ctl_t               ctl_s1,
	input  logic [PIXEL_BITS-1:0]            pix_s1,
	input  logic [$clog2(LINES)-1:0]         line_s1,
	input  logic [LINES-1:0][PIXEL_BITS-1:0] rd_line,
	input  logic [HW_W-1:0]                  half_width,
	input  logic [swlm_pkg::THR_W-1:0]       threshold,
	output logic                             hit,
	output swlm_pkg::peak_t                  peak
);

	import swlm_pkg::*;

	localparam int LW    = $clog2(LINES);
	localparam int CMP_W = (PIXEL_BITS > 16) ? PIXEL_BITS : 16;

	logic [LW-1:0]                           phys_idx [LINES];
	logic [LINES-1:0][PIXEL_BITS-1:0]        column_in;
	logic [LINES-1:0][LINES-1:0][PIXEL_BITS-1:0] win_q;
	win_ctl_t                                ctl_s2;
	logic [LW-1:0]                           mid;
	logic [PIXEL_BITS-1:0]                   centre;
	logic signed [CMP_W-1:0]                 centre_x;
	logic signed [CMP_W-1:0]                 thr_x;
	logic                                    is_max;
	int                                      span;
	int                                      hw;

	// Order the line reads by age: newest line is the incoming pixel itself
	always_comb begin
		for (int k = 0; k < LINES; k++) begin
			if (line_s1 >= LW'(k)) begin
				phys_idx[k] = line_s1 - LW'(k);
			end else begin
				phys_idx[k] = line_s1 + LW'(LINES - k);
			end
			if (k == 0) begin
				column_in[k] = pix_s1;
			end else begin
				column_in[k] = rd_line[phys_idx[k]];
			end
		end
	end

	// Shift the new column into the window, oldest column drops out
	always_ff @(posedge clk) begin
		if (en && ctl_s1.valid) begin
			for (int k = 0; k < LINES; k++) begin
				win_q[k] <= {win_q[k][LINES-2:0], column_in[k]};
			end
		end
	end

	// Advance the control of the pixel whose window is now complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Compare the centre against every other pixel of the square
	always_comb begin
		hw       = int'(half_width);
		span     = 2 * hw;
		mid      = LW'(half_width);
		centre   = win_q[mid][mid];
		centre_x = CMP_W'($signed(centre));
		thr_x    = CMP_W'({1'b0, threshold});
		is_max   = 1'b1;
		for (int k = 0; k < LINES; k++) begin
			for (int j = 0; j < LINES; j++) begin
				if ((k <= span) && (j <= span) && !((k == hw) && (j == hw)) &&
				    !($signed(win_q[k][j]) < $signed(centre))) begin
					is_max = 1'b0;
				end
			end
		end
	end

	assign hit        = ctl_s2.valid && ctl_s2.elig && (centre_x > thr_x) && is_max;
	assign peak.col   = ctl_s2.col;
	assign peak.row   = ctl_s2.row;
	assign peak.value = centre_x[VALUE_W-1:0];

endmodule

// ===== rtl/swlm_out_skid.sv =====
module swlm_out_skid (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  swlm_pkg::peak_t                  in_data,
	output logic                             space_ok,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [swlm_pkg::OUT_TDATA_W-1:0] out_data
);

	import swlm_pkg::*;

	logic  out_v_q;
	logic  skid_v_q;
	peak_t out_d_q;
	peak_t skid_d_q;
	logic  drain;
	logic  in_fire;

	assign drain   = !out_v_q || out_ready;
	assign in_fire = in_valid && !skid_v_q;

	// Refill the output from the skid first, park a request in the skid on a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	// Move the payload along the same paths
	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_v_q) begin
				out_d_q <= skid_d_q;
			end else if (in_fire) begin
				out_d_q <= in_data;
			end
		end else if (in_fire) begin
			skid_d_q <= in_data;
		end
	end

	assign space_ok  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = OUT_TDATA_W'(out_d_q);

endmodule

// ===== bench/tb_square_window_local_maximum_finder.sv =====
`timescale 1ns / 100ps

module tb_square_window_local_maximum_finder;
	import swlm_pkg::*;

	localparam int LINES          = 7;
	localparam int MAX_COLS       = 1024;
	localparam int MAX_ROWS_      = 1024;
	localparam int MAX_HALF       = 3;
	localparam int SMALL_BUDGET   = 1300;
	localparam int CALM_FROM      = 1100;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int PRINT_LIMIT    = 100;

	typedef enum int {
		FULL_RANGE,
		LOW_NOISE,
		DARK_SPARSE
	} pixel_mix_t;

	typedef struct packed {
		logic [15:0] pix;
		logic        sof;
		logic        typed;
		peak_t       peak;
	} stim_row_t;

	localparam peak_t CORNER_PEAK = '{value: 15'h7FFF, row: 10'd1, col: 10'd1};

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [15:0]               s_axis_tdata;  // pixel_value
	logic                      s_axis_tuser;  // start_of_frame
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [OUT_TDATA_W-1:0]    m_axis_tdata;  // peak_column, peak_row, peak_value

	// Predictor state: line memory, scan position and register copies
	logic signed [15:0]        line_mem [0:LINES-1][0:MAX_COLS-1];
	int                        next_col;
	int                        next_row;
	logic [THR_W-1:0]          thr_setting;
	logic [SQ_W-1:0]           half_width_setting;
	logic [FRAME_W-1:0]        columns_setting;
	logic [FRAME_W-1:0]        rows_setting;

	peak_t                     pending_peaks [$];
	int                        mismatch_count = 0;
	int                        cycle_count = 0;
	bit                        calm = 1'b0;
	bit                        hold_off_req = 1'b0;
	stim_row_t                 directed_rows [0:23];

	square_window_local_maximum_finder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Store the pixel, then test the centre whose window it completes
	task automatic find_peak(input logic [15:0] pix, input logic sof, output bit found,
			output peak_t pk);
		int cols, rows, s, c, r, cx, cy, centre, yy, xx, thr;
		bit is_max;
		cols = int'(columns_setting);
		rows = int'(rows_setting);
		cols = (cols < MIN_FRAME_DIM) ? MIN_FRAME_DIM : ((cols > MAX_COLS) ? MAX_COLS : cols);
		rows = (rows < MIN_FRAME_DIM) ? MIN_FRAME_DIM : ((rows > MAX_ROWS_) ? MAX_ROWS_ : rows);
		s = (half_width_setting == 0) ? 1 : int'(half_width_setting);
		if (s > MAX_HALF)
			s = MAX_HALF;
		thr = int'(thr_setting);
		c = sof ? 0 : next_col;
		r = sof ? 0 : next_row;
		if (c >= MAX_COLS)
			c = 0;
		if (r >= MAX_ROWS_)
			r = 0;
		line_mem[r % LINES][c] = pix;
		found = 1'b0;
		pk = '0;
		if (c >= 2 * s && c < cols && r >= 2 * s && r < rows) begin
			cx = c - s;
			cy = r - s;
			centre = line_mem[cy % LINES][cx];
			if (centre > thr) begin
				is_max = 1'b1;
				for (yy = cy - s; yy <= cy + s; yy++)
					for (xx = cx - s; xx <= cx + s; xx++)
						if (!(yy == cy && xx == cx) && !(line_mem[yy % LINES][xx] < centre))
							is_max = 1'b0;
				if (is_max) begin
					found = 1'b1;
					pk.col = cx[COORD_W-1:0];
					pk.row = cy[COORD_W-1:0];
					pk.value = centre[VALUE_W-1:0];
				end
			end
		end
		// Advance the raster position
		c++;
		if (c >= cols) begin
			c = 0;
			r++;
			if (r >= rows)
				r = 0;
		end
		next_col = c;
		next_row = r;
	endtask

	// Write all four registers back to back; junk fills bits above each width
	task automatic load_settings(input int thr, input int sq, input int cols, input int rows,
			input bit junk_bits);
		logic [CFG_DATA_W-1:0] junk;
		logic [CFG_DATA_W-1:0] data [4];
		cfg_reg_t index [4];
		junk = junk_bits ? CFG_DATA_W'($urandom) : '0;
		index = '{CFG_THRESHOLD, CFG_SQUARE_SIZE, CFG_FRAME_COLUMNS, CFG_FRAME_ROWS};
		data[0] = CFG_DATA_W'(thr);
		data[1] = (junk & ~CFG_DATA_W'(3)) | CFG_DATA_W'(sq & 3);
		data[2] = (junk & ~CFG_DATA_W'(11'h7FF)) | CFG_DATA_W'(cols & 11'h7FF);
		data[3] = (junk & ~CFG_DATA_W'(11'h7FF)) | CFG_DATA_W'(rows & 11'h7FF);
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= index[k];
			cfg_data <= data[k];
			@(posedge clk);
			case (index[k])
				CFG_THRESHOLD:     thr_setting = data[k][THR_W-1:0];
				CFG_SQUARE_SIZE:   half_width_setting = data[k][SQ_W-1:0];
				CFG_FRAME_COLUMNS: columns_setting = data[k][FRAME_W-1:0];
				CFG_FRAME_ROWS:    rows_setting = data[k][FRAME_W-1:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one pixel, hold until accepted, then queue what it yields
	task automatic feed_pixel(input logic [15:0] pix, input logic sof, input logic typed,
			input peak_t typed_peak);
		bit found;
		peak_t pk;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		s_axis_tuser <= sof;
		do
			@(posedge clk);
		while (!s_axis_tready);
		find_peak(pix, sof, found, pk);
		// Typed rows carry a peak read straight off the pattern
		if (typed) begin
			found = 1'b1;
			pk = typed_peak;
		end
		if (found)
			pending_peaks = {pending_peaks, pk};
	endtask

	task automatic idle_burst();
		s_axis_tvalid <= 1'b0;
		repeat ($urandom_range(1, 15)) @(posedge clk);
	endtask

	// Drop valid and wait for every queued peak, then let the pipe settle
	task automatic drain_peaks(input int extra);
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_peaks.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	function automatic logic [15:0] draw_pixel(input pixel_mix_t mix);
		int v;
		case (mix)
			FULL_RANGE: v = $urandom;
			LOW_NOISE:  v = ($urandom_range(0, 15) == 0) ? int'($urandom_range(1, 32767))
					: int'($urandom_range(0, 24)) - 12;
			default:    v = ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, 32767))
					: int'($urandom_range(0, 2767)) - 32768;
		endcase
		return v[15:0];
	endfunction

	// One stretch of frames: starts on a frame mark, optional stray marks
	task automatic run_frames(input int count, input pixel_mix_t mix, input bit gaps,
			input bit stray_marks, input int hold_at, input int pause_at);
		logic sof;
		for (int k = 0; k < count; k++) begin
			if (k == hold_at)
				hold_off_req = 1'b1;
			if (k == pause_at) begin
				s_axis_tvalid <= 1'b0;
				do
					@(posedge clk);
				while (pending_peaks.size() != 0);
			end
			sof = (k == 0) || (stray_marks && $urandom_range(0, 99) == 0);
			feed_pixel(draw_pixel(mix), sof, 1'b0, '0);
			if (gaps && !calm && $urandom_range(0, 5) == 0)
				idle_burst();
		end
		drain_peaks(SETTLE_CYCLES);
	endtask

	// Check each peak that leaves the block against the oldest expectation
	always @(posedge clk) begin
		peak_t got;
		peak_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[OUT_FIELDS_W-1:0];
			if (pending_peaks.size() == 0) begin
				report_mismatch($sformatf("unexpected peak col %0d row %0d value %0d",
						got.col, got.row, got.value));
			end else begin
				want = pending_peaks.pop_front();
				if (got.col != want.col)
					report_mismatch($sformatf("peak_column %0d, want %0d", got.col, want.col));
				if (got.row != want.row)
					report_mismatch($sformatf("peak_row %0d, want %0d", got.row, want.row));
				if (got.value != want.value)
					report_mismatch($sformatf("peak_value %0d, want %0d", got.value,
							want.value));
			end
		end
	end

	// Receiver: random stalls, one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		int small_items;
		int phase;
		int thr, sq, cols, rows, eff_cols, eff_rows, count, hold_at, pause_at;
		pixel_mix_t mix;
		bit gaps;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_THRESHOLD;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		next_col = 0;
		next_row = 0;
		thr_setting = THR_RESET;
		half_width_setting = SQ_RESET;
		columns_setting = FRAME_RESET;
		rows_setting = FRAME_RESET;

		// Eight-wide frame: a full-scale peak, a tie pair, extremes of the sample
		directed_rows = '{
			'{16'h8000, 1'b1, 1'b0, '0}, '{16'h8000, 1'b0, 1'b0, '0},
			'{16'h8000, 1'b0, 1'b0, '0}, '{16'h8000, 1'b0, 1'b0, '0},
			'{16'h8000, 1'b0, 1'b0, '0}, '{16'h8000, 1'b0, 1'b0, '0},
			'{16'h8000, 1'b0, 1'b0, '0}, '{16'h8000, 1'b0, 1'b0, '0},
			'{16'hFFFF, 1'b0, 1'b0, '0}, '{16'h7FFF, 1'b0, 1'b0, '0},
			'{16'h0000, 1'b0, 1'b0, '0}, '{16'h0000, 1'b0, 1'b0, '0},
			'{16'd100,  1'b0, 1'b0, '0}, '{16'd100,  1'b0, 1'b0, '0},
			'{16'h0000, 1'b0, 1'b0, '0}, '{16'd5,    1'b0, 1'b0, '0},
			'{16'h0000, 1'b0, 1'b0, '0}, '{16'h0000, 1'b0, 1'b0, '0},
			'{16'h0000, 1'b0, 1'b1, CORNER_PEAK}, '{16'h0000, 1'b0, 1'b0, '0},
			'{16'h0000, 1'b0, 1'b0, '0}, '{16'h0000, 1'b0, 1'b0, '0},
			'{16'h0000, 1'b0, 1'b0, '0}, '{16'h7FFF, 1'b0, 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		load_settings(0, 1, 8, 8, 1'b0);
		for (int k = 0; k < 24; k++) begin
			feed_pixel(directed_rows[k].pix, directed_rows[k].sof, directed_rows[k].typed,
					directed_rows[k].peak);
			if (k % 5 == 4)
				idle_burst();
		end
		drain_peaks(SETTLE_CYCLES);

		// Random frames
		small_items = 0;
		phase = 0;
		while (small_items < SMALL_BUDGET) begin
			calm = (small_items >= CALM_FROM);
			phase++;
			hold_at = -1;
			pause_at = -1;
			gaps = $urandom_range(0, 2) != 0;
			mix = pixel_mix_t'($urandom_range(0, 2));
			sq = $urandom_range(0, 3);
			cols = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 16);
			rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 12);
			case ($urandom_range(0, 3))
				0: thr = 0;
				1: thr = $urandom_range(0, 20);
				2: thr = $urandom_range(0, 32767);
				default: thr = $urandom_range(0, 3);
			endcase
			case (phase)
				1: begin
					// Long receiver hold-off with the sender pushing hard
					thr = 0; sq = 1; cols = 8; rows = 8;
					mix = FULL_RANGE; gaps = 1'b0; hold_at = 40;
				end
				2: begin
					thr = 10; sq = 2; cols = 12; rows = 10;
					mix = LOW_NOISE; pause_at = 90;
				end
				3: begin
					thr = 32767; sq = 1; cols = 10; rows = 8; mix = FULL_RANGE;
				end
				4: begin
					thr = 0; sq = 0; cols = 3; rows = 0; mix = LOW_NOISE;
				end
				5: begin
					thr = 0; sq = 3; cols = 16; rows = 9; mix = DARK_SPARSE;
				end
				default: ;
			endcase
			eff_cols = (cols < MIN_FRAME_DIM) ? MIN_FRAME_DIM : cols;
			eff_rows = (rows < MIN_FRAME_DIM) ? MIN_FRAME_DIM : rows;
			count = $urandom_range(eff_cols * eff_rows / 2, eff_cols * eff_rows * 2);
			if (phase == 1 && count < 300)
				count = 300;
			if (phase == 2 && count < 180)
				count = 180;
			load_settings(thr, sq, cols, rows, $urandom_range(0, 1));
			run_frames(count, mix, gaps, phase > 5, hold_at, pause_at);
			small_items += count;
		end

		drain_peaks(20);
		if (pending_peaks.size() != 0)
			report_mismatch($sformatf("%0d peaks never arrived", pending_peaks.size()));
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
